// ===== rtl/arithmetic_expression_lexer_unit_macros.svh =====
// Assertion macros for the arithmetic expression lexer checker.
// Holds only macro definitions; it depends on nothing else.
`ifndef ARITHMETIC_EXPRESSION_LEXER_UNIT_MACROS_SVH
`define ARITHMETIC_EXPRESSION_LEXER_UNIT_MACROS_SVH

// Implication within the same cycle, disabled while reset is asserted.
`define AEL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle, disabled while reset is asserted.
`define AEL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ael_pkg.sv =====
// Shared types and constants of the arithmetic expression lexer.
// Used by the lexer top level and its checker; depends on nothing.
package ael_pkg;

    // Token kinds carried on the output tuser.
    typedef enum logic [2:0] {
        KIND_NUMBER   = 3'd0,
        KIND_OPERATOR = 3'd1,
        KIND_LPAREN   = 3'd2,
        KIND_RPAREN   = 3'd3,
        KIND_ERROR    = 3'd4
    } t_kind;

    // Field widths fixed by the token format.
    localparam int CHAR_W   = 8;
    localparam int LENGTH_W = 6;

    // Token queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int COUNT_W     = 3;

    // Characters with a meaning of their own.
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CHAR_POINT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_VT     = 8'h0B;
    localparam logic [CHAR_W-1:0] CHAR_FF     = 8'h0C;
    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

endpackage

// ===== rtl/arithmetic_expression_lexer_unit.sv =====
// Top level of the arithmetic expression lexer: character classifier, position
// counters, pending number state and a small token queue. Depends on ael_pkg.

// The lexer takes one text byte per request on the slave stream and returns
// tokens on the master stream. Every request is lexed in the cycle it is
// accepted, so the input sustains one byte per clock while s_axis_tready is
// high. Tokens pass through a four-entry register queue and s_axis_tready is
// high while at most one token waits in it; a byte that both flushes a number
// and gives an operator or parenthesis token fills two entries, so the input
// may stall after it until at most one token waits. The first token of a
// request can be taken on the cycle after acceptance. After an error token the
// lexer drops all further requests without results until reset.
module arithmetic_expression_lexer_unit #(
    parameter int MAX_NUMBER_CHARS = 32,
    parameter int POSITION_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream. tdata: character [7:0]. tlast: end_of_text.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                s_axis_tlast,
    // Output stream. tdata from bit 0 up: token_char [7:0], number_length [13:8],
    // number_has_point [14], token_line, token_column (POSITION_BITS each),
    // zero fill. tuser: token_kind. tlast: last_token.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [((ael_pkg::CHAR_W + ael_pkg::LENGTH_W + 1 + 2 * POSITION_BITS + 7)
                   / 8) * 8 - 1:0] m_axis_tdata,
    output logic [2:0]          m_axis_tuser,
    output logic                m_axis_tlast
);

    localparam int FIELDS_W = ael_pkg::CHAR_W + ael_pkg::LENGTH_W + 1 + 2 * POSITION_BITS;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELDS_W;

    typedef struct packed {
        ael_pkg::t_kind                 kind;
        logic [ael_pkg::CHAR_W-1:0]     chr;
        logic [ael_pkg::LENGTH_W-1:0]   len;
        logic                           point;
        logic [POSITION_BITS-1:0]       line;
        logic [POSITION_BITS-1:0]       column;
        logic                           last;
    } t_token;

    // Lexer state.
    logic [POSITION_BITS-1:0]       r_line,     n_line;
    logic [POSITION_BITS-1:0]       r_column,   n_column;
    logic [ael_pkg::LENGTH_W-1:0]   r_pend_len, n_pend_len;
    logic                           r_point,    n_point;
    logic                           r_halted,   n_halted;

    // Token queue.
    t_token                         r_queue [ael_pkg::QUEUE_DEPTH];
    logic [ael_pkg::PTR_W-1:0]      r_wr_ptr,   n_wr_ptr;
    logic [ael_pkg::PTR_W-1:0]      r_rd_ptr,   n_rd_ptr;
    logic [ael_pkg::COUNT_W-1:0]    r_count,    n_count;

    logic                           in_accept;
    logic                           out_accept;
    logic [1:0]                     push;
    t_token                         tok0;
    t_token                         tok1;
    t_token                         num_tok;
    t_token                         head;
    logic [ael_pkg::CHAR_W-1:0]     chr;
    logic                           is_symbol;
    logic                           is_digit;
    logic                           is_point;
    logic                           is_skip;
    logic                           fits;
    logic [POSITION_BITS-1:0]       pend_len_ext;
    logic [POSITION_BITS-1:0]       column_inc;
    logic [POSITION_BITS-1:0]       line_inc;
    ael_pkg::t_kind                 sym_kind;

    // Handshakes; ready depends on queue occupancy only.
    assign s_axis_tready = (r_count <= ael_pkg::COUNT_W'(1));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign out_accept    = m_axis_tvalid && m_axis_tready;

    // Character classes.
    assign chr       = s_axis_tdata;
    assign is_symbol = (chr == ael_pkg::CHAR_PLUS)   || (chr == ael_pkg::CHAR_MINUS) ||
                       (chr == ael_pkg::CHAR_STAR)   || (chr == ael_pkg::CHAR_SLASH) ||
                       (chr == ael_pkg::CHAR_LPAREN) || (chr == ael_pkg::CHAR_RPAREN);
    assign is_digit  = (chr >= ael_pkg::CHAR_ZERO) && (chr <= ael_pkg::CHAR_NINE);
    assign is_point  = (chr == ael_pkg::CHAR_POINT);
    assign is_skip   = (chr == ael_pkg::CHAR_TAB) || (chr == ael_pkg::CHAR_CR) ||
                       (chr == ael_pkg::CHAR_VT)  || (chr == ael_pkg::CHAR_FF);
    assign fits      = ({1'b0, r_pend_len} + 7'd1) <= 7'(MAX_NUMBER_CHARS);

    assign sym_kind  = (chr == ael_pkg::CHAR_LPAREN) ? ael_pkg::KIND_LPAREN :
                       (chr == ael_pkg::CHAR_RPAREN) ? ael_pkg::KIND_RPAREN :
                                                       ael_pkg::KIND_OPERATOR;

    // Saturating counter steps.
    assign column_inc = (r_column == '1) ? r_column : r_column + 1'b1;
    assign line_inc   = (r_line == '1) ? r_line : r_line + 1'b1;

    // The pending number as a token; its start column clamps at zero.
    assign pend_len_ext = POSITION_BITS'(r_pend_len);
    always_comb begin
        num_tok        = '0;
        num_tok.kind   = ael_pkg::KIND_NUMBER;
        num_tok.len    = r_pend_len;
        num_tok.point  = r_point;
        num_tok.line   = r_line;
        num_tok.column = (r_column >= pend_len_ext) ? r_column - pend_len_ext : '0;
    end

    // Lexing of one accepted request.
    always_comb begin
        n_line     = r_line;
        n_column   = r_column;
        n_pend_len = r_pend_len;
        n_point    = r_point;
        n_halted   = r_halted;
        push       = 2'd0;
        tok0       = '0;
        tok1       = '0;

        if (in_accept && !r_halted) begin
            priority if (s_axis_tlast) begin
                if (r_pend_len != '0) begin
                    tok0 = num_tok;
                    push = 2'd1;
                end
                n_pend_len = '0;
                n_point    = 1'b0;
            end else if (is_symbol) begin
                tok1        = '0;
                tok1.kind   = sym_kind;
                tok1.chr    = chr;
                tok1.line   = r_line;
                tok1.column = r_column;
                if (r_pend_len != '0) begin
                    tok0 = num_tok;
                    push = 2'd2;
                end else begin
                    tok0 = tok1;
                    push = 2'd1;
                end
                n_pend_len = '0;
                n_point    = 1'b0;
                n_column   = column_inc;
            end else if (chr == ael_pkg::CHAR_SPACE) begin
                if (r_pend_len != '0) begin
                    tok0 = num_tok;
                    push = 2'd1;
                end
                n_pend_len = '0;
                n_point    = 1'b0;
                n_column   = column_inc;
            end else if (chr == ael_pkg::CHAR_NL) begin
                n_line   = line_inc;
                n_column = POSITION_BITS'(1);
            end else if (is_skip) begin
                n_column = column_inc;
            end else if ((is_digit || (is_point && !r_point)) && fits) begin
                n_pend_len = r_pend_len + 1'b1;
                n_point    = r_point || is_point;
                n_column   = column_inc;
            end else begin
                // Illegal character, second point or over-long number.
                tok0.kind   = ael_pkg::KIND_ERROR;
                tok0.chr    = chr;
                tok0.line   = r_line;
                tok0.column = r_column;
                push        = 2'd1;
                n_pend_len  = '0;
                n_point     = 1'b0;
                n_halted    = 1'b1;
            end
        end

        // The final token of the request carries the last flag.
        tok0.last = (push == 2'd1);
        tok1.last = 1'b1;
    end

    // Queue pointers and occupancy.
    always_comb begin
        n_wr_ptr = r_wr_ptr + ael_pkg::PTR_W'(push);
        n_rd_ptr = r_rd_ptr + ael_pkg::PTR_W'(out_accept);
        n_count  = r_count + ael_pkg::COUNT_W'(push) - ael_pkg::COUNT_W'(out_accept);
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= POSITION_BITS'(1);
            r_column   <= POSITION_BITS'(1);
            r_pend_len <= '0;
            r_point    <= 1'b0;
            r_halted   <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_line     <= n_line;
            r_column   <= n_column;
            r_pend_len <= n_pend_len;
            r_point    <= n_point;
            r_halted   <= n_halted;
            r_wr_ptr   <= n_wr_ptr;
            r_rd_ptr   <= n_rd_ptr;
            r_count    <= n_count;
        end
    end

    // Token storage: up to two entries written per cycle.
    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_queue[r_wr_ptr] <= tok0;
        end
        if (push == 2'd2) begin
            r_queue[ael_pkg::PTR_W'(r_wr_ptr + 1'b1)] <= tok1;
        end
    end

    // Output from the queue head.
    assign head         = r_queue[r_rd_ptr];
    assign m_axis_tdata = {{PAD_W{1'b0}}, head.column, head.line, head.point, head.len,
                           head.chr};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

// ===== rtl/ael_checker.sv =====
// Port-level checker for the arithmetic expression lexer and its bind.
// Depends on ael_pkg and arithmetic_expression_lexer_unit_macros.svh.
`include "arithmetic_expression_lexer_unit_macros.svh"

module ael_checker #(
    parameter int TDATA_W = 48
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [2:0]         m_axis_tuser,
    input logic               m_axis_tlast
);

    // A stalled token holds its contents.
    `AEL_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled token changed")

    // A number token has a length and no character.
    `AEL_ASSERT_SAME(a_number_form, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ael_pkg::KIND_NUMBER), (m_axis_tdata[13:8] != 6'd0) && (m_axis_tdata[7:0] == 8'd0), "malformed number token")

    // Any other token has no length and no point.
    `AEL_ASSERT_SAME(a_symbol_form, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ael_pkg::KIND_NUMBER), (m_axis_tdata[13:8] == 6'd0) && !m_axis_tdata[14], "token other than a number carries a length")

    // An error token ends its request and nothing follows it.
    `AEL_ASSERT_NEXT(a_error_final, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && (m_axis_tuser == ael_pkg::KIND_ERROR), !m_axis_tvalid && $past(m_axis_tlast), "token delivered after an error")

endmodule

bind arithmetic_expression_lexer_unit ael_checker #(
    .TDATA_W(TDATA_W)
) u_ael_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
